// ===== hw/rtl/efhc_pkg.sv =====
// Package for the Ethernet frame header classifier: widths, protocol constants,
// verdict and register codes, and the structs passed between the modules.
// No dependencies.
package efhc_pkg;

    // Frame length limit; the byte counter saturates here.
    localparam int MAX_FRAME_BYTES = 16383;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    // Field widths of the channels.
    localparam int BYTE_W    = 8;
    localparam int VERDICT_W = 3;
    localparam int KEY_W     = 32;
    localparam int TYPE_W    = 16;
    localparam int ADDR_W    = 48;
    localparam int OFF_W     = 5;
    localparam int PL_W      = 14;
    localparam int PL_MAX    = (1 << PL_W) - 1;
    localparam int CFG_IDX_W = 2;

    // Header layout, counted from the start of the (possibly shifted) header.
    localparam int DA_END          = 6;
    localparam int SA_END          = 12;
    localparam int HDR_LEN         = 14;
    localparam int PFX_END         = 16;
    localparam int FABRIC_SKIP     = 16;
    localparam int FABRIC_TYPE_IDX = 13;
    localparam int SHORT_FRAME_MAX = 16;
    localparam int MIN_PREFIX_LEN  = 2;

    localparam logic [TYPE_W-1:0] FABRIC_TYPE   = 16'h8903;
    localparam logic [TYPE_W-1:0] ETHERTYPE_MIN = 16'd1536;
    localparam logic [TYPE_W-1:0] LEN_MAX_8023  = 16'd1500;
    localparam logic [TYPE_W-1:0] SNAP_PREFIX   = 16'hAAAA;
    localparam logic [TYPE_W-1:0] IPX_PREFIX    = 16'hFFFF;

    typedef enum logic [VERDICT_W-1:0] {
        V_ETHERTYPE     = 3'd0,
        V_SNAP          = 3'd1,
        V_RAW_IPX       = 3'd2,
        V_LLC           = 3'd3,
        V_TRUNC_FRAME   = 3'd4,
        V_TRUNC_FABRIC  = 3'd5,
        V_UNDEF_TYPE    = 3'd6
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SNAP_KEY    = 2'd0,
        CFG_RAW_IPX_KEY = 2'd1,
        CFG_LLC_KEY     = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last_byte;
    } t_byte_item;

    typedef struct packed {
        logic [CNT_W-1:0]  len;
        logic              fabric;
        logic [TYPE_W-1:0] type_word;
        logic [ADDR_W-1:0] dest_addr;
        logic [ADDR_W-1:0] src_addr;
        logic [TYPE_W-1:0] prefix;
    } t_frame_sum;

    typedef struct packed {
        logic [KEY_W-1:0] snap_key;
        logic [KEY_W-1:0] raw_ipx_key;
        logic [KEY_W-1:0] llc_key;
    } t_keys;

    typedef struct packed {
        t_verdict          verdict;
        logic [KEY_W-1:0]  next_key;
        logic [TYPE_W-1:0] type_word;
        logic [ADDR_W-1:0] dest_addr;
        logic [ADDR_W-1:0] src_addr;
        logic [OFF_W-1:0]  payload_offset;
        logic [PL_W-1:0]   payload_length;
    } t_result;

endpackage

// ===== hw/rtl/efhc_if.sv =====
// Valid/ready channel interfaces of the frame header classifier: the byte
// stream, the configuration write channel and the result channel.
// Depends on efhc_pkg for field widths.
interface efhc_byte_if;
    logic                             valid;
    logic                             ready;
    logic [efhc_pkg::BYTE_W-1:0]      frame_byte;
    logic                             last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface efhc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [efhc_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [efhc_pkg::KEY_W-1:0]       wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

interface efhc_res_if;
    logic                             valid;
    logic                             ready;
    logic [efhc_pkg::VERDICT_W-1:0]   verdict;
    logic [efhc_pkg::KEY_W-1:0]       next_key;
    logic [efhc_pkg::TYPE_W-1:0]      type_word;
    logic [efhc_pkg::ADDR_W-1:0]      dest_addr;
    logic [efhc_pkg::ADDR_W-1:0]      src_addr;
    logic [efhc_pkg::OFF_W-1:0]       payload_offset;
    logic [efhc_pkg::PL_W-1:0]        payload_length;

    modport source (output valid, output verdict, output next_key, output type_word,
                    output dest_addr, output src_addr, output payload_offset,
                    output payload_length, input ready);
    modport sink (input valid, input verdict, input next_key, input type_word,
                  input dest_addr, input src_addr, input payload_offset,
                  input payload_length, output ready);
endinterface

// ===== hw/rtl/efhc_frame_parser.sv =====
// Per-frame header capture: byte counter, fabric header detection and the
// address, type and prefix shift registers, with a frame summary register.
// Depends on efhc_pkg.
module efhc_frame_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  efhc_pkg::t_byte_item  i_item,
    output logic                  o_ready,
    output logic                  o_sum_valid,
    output efhc_pkg::t_frame_sum  o_sum,
    input  logic                  i_sum_ready
);
    import efhc_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_fabric, n_fabric;
    logic [ADDR_W-1:0] r_dest, n_dest;
    logic [ADDR_W-1:0] r_src, n_src;
    logic [TYPE_W-1:0] r_type, n_type;
    logic [TYPE_W-1:0] r_prefix, n_prefix;
    logic              r_sum_valid;
    t_frame_sum        r_sum;

    logic              fire;
    logic              saturated;
    logic              in_hdr;
    logic [CNT_W-1:0]  rel;

    assign o_ready     = !r_sum_valid || i_sum_ready;
    assign fire        = i_valid && o_ready;
    assign o_sum_valid = r_sum_valid;
    assign o_sum       = r_sum;

    // Each byte shifts into the field that its position within the header
    // selects; with a fabric header the header starts FABRIC_SKIP bytes later.
    always_comb begin
        saturated = (r_count == CNT_W'(MAX_FRAME_BYTES));
        in_hdr    = !r_fabric || (r_count >= CNT_W'(FABRIC_SKIP));
        rel       = r_fabric ? (r_count - CNT_W'(FABRIC_SKIP)) : r_count;
        n_count   = r_count;
        n_fabric  = r_fabric;
        n_dest    = r_dest;
        n_src     = r_src;
        n_type    = r_type;
        n_prefix  = r_prefix;
        if (!saturated) begin
            n_count = r_count + CNT_W'(1);
            if (in_hdr && rel < CNT_W'(DA_END)) begin
                n_dest = {r_dest[ADDR_W-BYTE_W-1:0], i_item.frame_byte};
            end else if (in_hdr && rel < CNT_W'(SA_END)) begin
                n_src = {r_src[ADDR_W-BYTE_W-1:0], i_item.frame_byte};
            end else if (in_hdr && rel < CNT_W'(HDR_LEN)) begin
                n_type = {r_type[TYPE_W-BYTE_W-1:0], i_item.frame_byte};
            end else if (in_hdr && rel < CNT_W'(PFX_END)) begin
                n_prefix = {r_prefix[TYPE_W-BYTE_W-1:0], i_item.frame_byte};
            end
            if (r_count == CNT_W'(FABRIC_TYPE_IDX) && !r_fabric && n_type == FABRIC_TYPE) begin
                n_fabric = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_fabric    <= 1'b0;
            r_sum_valid <= 1'b0;
        end else begin
            if (fire) begin
                if (i_item.last_byte) begin
                    r_count  <= '0;
                    r_fabric <= 1'b0;
                end else begin
                    r_count  <= n_count;
                    r_fabric <= n_fabric;
                end
            end
            if (fire && i_item.last_byte) begin
                r_sum_valid <= 1'b1;
            end else if (i_sum_ready) begin
                r_sum_valid <= 1'b0;
            end
        end
    end

    // Capture registers are always fully overwritten before they are used.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_dest   <= n_dest;
            r_src    <= n_src;
            r_type   <= n_type;
            r_prefix <= n_prefix;
        end
        if (fire && i_item.last_byte) begin
            r_sum.len       <= n_count;
            r_sum.fabric    <= n_fabric;
            r_sum.type_word <= n_type;
            r_sum.dest_addr <= n_dest;
            r_sum.src_addr  <= n_src;
            r_sum.prefix    <= n_prefix;
        end
    end

endmodule

// ===== hw/rtl/efhc_classifier.sv =====
// Frame verdict logic: classifies a completed frame summary as EtherType,
// 802.3 SNAP, raw IPX, LLC or one of the error classes.
// Depends on efhc_pkg.
module efhc_classifier (
    input  efhc_pkg::t_frame_sum i_sum,
    input  efhc_pkg::t_keys      i_keys,
    output efhc_pkg::t_result    o_result
);
    import efhc_pkg::*;

    localparam int SUM_W = (CNT_W > PL_W) ? CNT_W : PL_W;

    logic [SUM_W-1:0] len_x;
    logic [SUM_W-1:0] hdr_end;
    logic [SUM_W-1:0] plen;

    always_comb begin
        len_x    = SUM_W'(i_sum.len);
        hdr_end  = i_sum.fabric ? SUM_W'(FABRIC_SKIP + HDR_LEN) : SUM_W'(HDR_LEN);
        plen     = len_x - hdr_end;
        o_result = '0;
        if (len_x <= SUM_W'(SHORT_FRAME_MAX)) begin
            o_result.verdict = V_TRUNC_FRAME;
        end else if (i_sum.fabric && len_x <= SUM_W'(FABRIC_SKIP + HDR_LEN)) begin
            o_result.verdict = V_TRUNC_FABRIC;
        end else begin
            o_result.type_word = i_sum.type_word;
            o_result.dest_addr = i_sum.dest_addr;
            o_result.src_addr  = i_sum.src_addr;
            if (i_sum.type_word >= ETHERTYPE_MIN) begin
                o_result.verdict        = V_ETHERTYPE;
                o_result.next_key       = KEY_W'(i_sum.type_word);
                o_result.payload_offset = OFF_W'(hdr_end);
            end else if (i_sum.type_word <= LEN_MAX_8023) begin
                if (plen < SUM_W'(MIN_PREFIX_LEN)) begin
                    o_result.verdict = V_TRUNC_FRAME;
                end else begin
                    // 802.3: the payload never runs past the length field.
                    if (plen > SUM_W'(i_sum.type_word)) begin
                        plen = SUM_W'(i_sum.type_word);
                    end
                    o_result.payload_offset = OFF_W'(hdr_end);
                    if (i_sum.prefix == SNAP_PREFIX) begin
                        o_result.verdict  = V_SNAP;
                        o_result.next_key = i_keys.snap_key;
                    end else if (i_sum.prefix == IPX_PREFIX) begin
                        o_result.verdict  = V_RAW_IPX;
                        o_result.next_key = i_keys.raw_ipx_key;
                    end else begin
                        o_result.verdict  = V_LLC;
                        o_result.next_key = i_keys.llc_key;
                    end
                end
            end else begin
                o_result.verdict = V_UNDEF_TYPE;
            end
            if (o_result.verdict == V_ETHERTYPE || o_result.verdict == V_SNAP
                || o_result.verdict == V_RAW_IPX || o_result.verdict == V_LLC) begin
                if (plen > SUM_W'(PL_MAX)) begin
                    plen = SUM_W'(PL_MAX);
                end
                o_result.payload_length = plen[PL_W-1:0];
            end
        end
    end

endmodule

// ===== hw/rtl/ethernet_frame_header_classifier_top.sv =====
// Top level of the Ethernet frame header classifier: input byte register,
// frame parser, verdict logic, key registers and the result register.
// Depends on efhc_pkg, efhc_if, efhc_frame_parser and efhc_classifier.

// The classifier takes an Ethernet frame one byte per transfer on i_byte, in
// wire order, with last_byte set on the final byte, and gives exactly one
// result transfer on o_res per frame, none for the other bytes. It accepts one
// byte in every clock cycle, sustained, as long as results are taken. The
// path is three registers deep: the byte register, the frame summary
// register written by the parser on the last byte, and the result register
// loaded from the verdict logic.
// Each register stage moves on when the next one is free or being emptied, so
// a stall at o_res holds up new bytes only once all three stages are full.
// When bytes 12 and 13 carry the fabric-path type, a 16-byte fabric header is
// skipped and the addresses, the type/length word and the payload are taken
// 16 bytes later. Types of 1536 and above are EtherTypes; lengths of 1500 and
// below mark 802.3 frames, classed by their first two payload bytes as SNAP,
// raw IPX or LLC, and their payload length is clamped to the length field.
// Frames that are too short, and values between the two ranges, give the
// error verdicts. The byte count saturates at efhc_pkg::MAX_FRAME_BYTES.
// The three 802.3 keys are written through i_cfg (index 0 SNAP, 1 raw IPX,
// 2 LLC; other indexes are ignored), which is always ready; write them only
// while no frame is in flight. All keys reset to zero.
module ethernet_frame_header_classifier_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    efhc_byte_if.sink      i_byte,
    efhc_cfg_if.sink       i_cfg,
    efhc_res_if.source     o_res
);
    import efhc_pkg::*;

    // Input byte register.
    logic       r_in_valid;
    t_byte_item r_in;
    logic       in_ready;
    logic       in_fire;

    // Parser handshake toward the byte register and the result register.
    logic       parse_ready;
    logic       sum_valid;
    t_frame_sum sum;

    // Key registers written through the configuration channel.
    t_keys      r_keys, n_keys;

    // Result register.
    t_result    result;
    t_result    r_out;
    logic       r_out_valid;
    logic       out_free;
    logic       sum_take;

    // The result register frees up when empty or when its transfer completes.
    assign out_free = !r_out_valid || o_res.ready;
    assign sum_take = sum_valid && out_free;

    // The byte register refills in the same cycle the parser consumes it.
    assign in_ready     = !r_in_valid || parse_ready;
    assign in_fire      = i_byte.valid && in_ready;
    assign i_byte.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.frame_byte <= i_byte.frame_byte;
            r_in.last_byte  <= i_byte.last_byte;
        end
    end

    efhc_frame_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_item      (r_in),
        .o_ready     (parse_ready),
        .o_sum_valid (sum_valid),
        .o_sum       (sum),
        .i_sum_ready (out_free)
    );

    // Key registers; a write to an unused index leaves them unchanged.
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_keys = r_keys;
        if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.reg_index))
                CFG_SNAP_KEY:    n_keys.snap_key    = i_cfg.wr_data;
                CFG_RAW_IPX_KEY: n_keys.raw_ipx_key = i_cfg.wr_data;
                CFG_LLC_KEY:     n_keys.llc_key     = i_cfg.wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else begin
            r_keys <= n_keys;
        end
    end

    efhc_classifier u_classifier (
        .i_sum    (sum),
        .i_keys   (r_keys),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_take) begin
            r_out <= result;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.verdict        = r_out.verdict;
    assign o_res.next_key       = r_out.next_key;
    assign o_res.type_word      = r_out.type_word;
    assign o_res.dest_addr      = r_out.dest_addr;
    assign o_res.src_addr       = r_out.src_addr;
    assign o_res.payload_offset = r_out.payload_offset;
    assign o_res.payload_length = r_out.payload_length;

`ifndef ASSERT_OFF
    // A truncated fabric header reports nothing but its verdict.
    a_trunc_fabric_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict == V_TRUNC_FABRIC) |->
        (r_out.next_key == '0 && r_out.type_word == '0 && r_out.dest_addr == '0
         && r_out.src_addr == '0 && r_out.payload_offset == '0
         && r_out.payload_length == '0))
        else $error("truncated fabric verdict carries nonzero fields");

    // An EtherType verdict forwards the captured type word as its key.
    a_ethertype_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.verdict == V_ETHERTYPE) |->
        (r_out.type_word >= ETHERTYPE_MIN && r_out.next_key == KEY_W'(r_out.type_word)))
        else $error("EtherType verdict with inconsistent key or type");

    // Payload offset is zero, the plain header length or past a fabric header.
    a_offset_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
        (r_out.payload_offset == '0 || r_out.payload_offset == OFF_W'(HDR_LEN)
         || r_out.payload_offset == OFF_W'(FABRIC_SKIP + HDR_LEN)))
        else $error("unexpected payload offset");

    // An 802.3 verdict never forwards more payload than the length field allows.
    a_8023_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.verdict == V_SNAP || r_out.verdict == V_RAW_IPX
                         || r_out.verdict == V_LLC)) |->
        (TYPE_W'(r_out.payload_length) <= r_out.type_word))
        else $error("802.3 payload length not clamped to the length field");
`endif

endmodule

// ===== tb/sv/efhc_verdict_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the frame header classifier: follows key writes and the
// byte stream, predicts one verdict per frame and compares it with o_res.
// Depends on efhc_pkg and the channel interfaces of efhc_if.
module efhc_verdict_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    efhc_byte_if  i_byte_mon,
    efhc_cfg_if   i_cfg_mon,
    efhc_res_if   i_res_mon,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked
);
    import efhc_pkg::*;

    // Predicted state of the frame being parsed, and the key registers.
    logic [CNT_W-1:0]  frame_len;
    logic              fabric_hdr;
    logic [TYPE_W-1:0] cap_type;
    logic [TYPE_W-1:0] cap_prefix;
    logic [ADDR_W-1:0] cap_dest;
    logic [ADDR_W-1:0] cap_src;
    t_keys             keys;

    t_result expected_verdicts[$];
    int      fail_count = 0;
    int      checked = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;

    task automatic clear_frame();
        frame_len  = '0;
        fabric_hdr = 1'b0;
        cap_type   = '0;
        cap_prefix = '0;
        cap_dest   = '0;
        cap_src    = '0;
    endtask

    // Shift one byte into whichever header field its position falls in. Once the
    // fabric-path type is seen at bytes 12-13, every field moves 16 bytes later.
    task automatic absorb_byte(input logic [BYTE_W-1:0] b);
        int idx;
        int base;
        idx  = int'(frame_len);
        base = fabric_hdr ? FABRIC_SKIP : 0;
        if (frame_len < MAX_FRAME_BYTES) begin
            if (idx >= base && idx < base + DA_END)
                cap_dest = {cap_dest[ADDR_W-BYTE_W-1:0], b};
            else if (idx >= base + DA_END && idx < base + SA_END)
                cap_src = {cap_src[ADDR_W-BYTE_W-1:0], b};
            else if (idx >= base + SA_END && idx < base + HDR_LEN)
                cap_type = {cap_type[TYPE_W-BYTE_W-1:0], b};
            else if (idx >= base + HDR_LEN && idx < base + PFX_END)
                cap_prefix = {cap_prefix[TYPE_W-BYTE_W-1:0], b};
            if (idx == FABRIC_TYPE_IDX && !fabric_hdr && cap_type == FABRIC_TYPE)
                fabric_hdr = 1'b1;
            frame_len = frame_len + 1'b1;
        end
    endtask

    function automatic t_result classify_frame();
        t_result r;
        int      base;
        int      plen;
        r    = '0;
        base = fabric_hdr ? FABRIC_SKIP : 0;
        if (frame_len <= SHORT_FRAME_MAX) begin
            r.verdict = V_TRUNC_FRAME;
        end else if (fabric_hdr && frame_len <= FABRIC_SKIP + HDR_LEN) begin
            r.verdict = V_TRUNC_FABRIC;
        end else begin
            plen        = int'(frame_len) - base - HDR_LEN;
            r.type_word = cap_type;
            r.dest_addr = cap_dest;
            r.src_addr  = cap_src;
            if (cap_type >= ETHERTYPE_MIN) begin
                r.verdict        = V_ETHERTYPE;
                r.next_key       = KEY_W'(cap_type);
                r.payload_offset = OFF_W'(base + HDR_LEN);
                r.payload_length = PL_W'(plen);
            end else if (cap_type <= LEN_MAX_8023) begin
                if (plen < MIN_PREFIX_LEN) begin
                    r.verdict = V_TRUNC_FRAME;
                end else begin
                    // 802.3 payload never runs past its length field.
                    if (plen > int'(cap_type))
                        plen = int'(cap_type);
                    r.payload_offset = OFF_W'(base + HDR_LEN);
                    r.payload_length = PL_W'(plen);
                    if (cap_prefix == SNAP_PREFIX) begin
                        r.verdict  = V_SNAP;
                        r.next_key = keys.snap_key;
                    end else if (cap_prefix == IPX_PREFIX) begin
                        r.verdict  = V_RAW_IPX;
                        r.next_key = keys.raw_ipx_key;
                    end else begin
                        r.verdict  = V_LLC;
                        r.next_key = keys.llc_key;
                    end
                end
            end else begin
                r.verdict = V_UNDEF_TYPE;
            end
        end
        return r;
    endfunction

    task automatic flag_field(input string name, input logic [63:0] want_v,
                              input logic [63:0] got_v);
        fail_count++;
        $error("verdict #%0d: %s expected 0x%0h, got 0x%0h", checked, name, want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_frame();
            keys = '0;
            expected_verdicts.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (i_cfg_mon.reg_index)
                    CFG_SNAP_KEY:    keys.snap_key    = i_cfg_mon.wr_data;
                    CFG_RAW_IPX_KEY: keys.raw_ipx_key = i_cfg_mon.wr_data;
                    CFG_LLC_KEY:     keys.llc_key     = i_cfg_mon.wr_data;
                    default: ;
                endcase
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                got.verdict        = t_verdict'(i_res_mon.verdict);
                got.next_key       = i_res_mon.next_key;
                got.type_word      = i_res_mon.type_word;
                got.dest_addr      = i_res_mon.dest_addr;
                got.src_addr       = i_res_mon.src_addr;
                got.payload_offset = i_res_mon.payload_offset;
                got.payload_length = i_res_mon.payload_length;
                if (expected_verdicts.size() == 0) begin
                    fail_count++;
                    $error("unexpected result transfer, verdict %0d", got.verdict);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.verdict !== want.verdict)
                        flag_field("verdict", want.verdict, got.verdict);
                    if (got.next_key !== want.next_key)
                        flag_field("next_key", want.next_key, got.next_key);
                    if (got.type_word !== want.type_word)
                        flag_field("type_word", want.type_word, got.type_word);
                    if (got.dest_addr !== want.dest_addr)
                        flag_field("dest_addr", want.dest_addr, got.dest_addr);
                    if (got.src_addr !== want.src_addr)
                        flag_field("src_addr", want.src_addr, got.src_addr);
                    if (got.payload_offset !== want.payload_offset)
                        flag_field("payload_offset", want.payload_offset, got.payload_offset);
                    if (got.payload_length !== want.payload_length)
                        flag_field("payload_length", want.payload_length, got.payload_length);
                    checked++;
                end
            end
            if (i_byte_mon.valid && i_byte_mon.ready) begin
                absorb_byte(i_byte_mon.frame_byte);
                if (i_byte_mon.last_byte) begin
                    expected_verdicts.push_back(classify_frame());
                    clear_frame();
                end
            end
        end
        o_pending <= expected_verdicts.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Top of the frame header classifier testbench: clock, reset, frame and key
// stimulus, back-pressure on the result channel and the final verdict.
// Depends on efhc_pkg, efhc_if, the classifier RTL and efhc_verdict_checker.
module tb;
    import efhc_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int CYCLE_LIMIT    = 400000;
    // Length of the one long receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES    = 300;
    // Cycles allowed after the last expected result before keys change or the
    // run ends; the pipeline is three registers deep.
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_BYTES    = 240;

    // Index with no register behind it; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_INDEX = 2'd3;
    localparam logic [TYPE_W-1:0]    ETYPE_IPV4    = 16'h0800;
    localparam logic [TYPE_W-1:0]    TYPE_ALL_ONES = 16'hFFFF;
    localparam logic [KEY_W-1:0]     KEY_ALL_ONES  = 32'hFFFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // Idle rates in percent for each side; the stimulus changes them per phase.
    int src_idle_pct;
    int snk_idle_pct;
    // Bumping the token asks the receiver process for one long hold-off.
    int stall_token;
    int stall_seen = 0;
    int hold_left = 0;

    int cycle_count;
    int bytes_sent;
    int frames_sent;
    int fail_count;
    int pending;
    int checked;

    efhc_byte_if byte_ch ();
    efhc_cfg_if  cfg_ch ();
    efhc_res_if  res_ch ();

    ethernet_frame_header_classifier_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    efhc_verdict_checker verdict_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_mon   (byte_ch),
        .i_cfg_mon    (cfg_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // The receiver takes results at random, except during the one long hold-off,
    // when it refuses everything so that all pipeline stages fill and the block
    // has to stall its byte input.
    always @(posedge i_clk) begin
        if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // One byte transfer, preceded by a random number of idle cycles. Valid stays
    // high from one byte to the next when no idle cycle is drawn.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.frame_byte <= b;
        byte_ch.last_byte  <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // A frame of random bytes with the header fields planted where the block
    // looks for them. With a fabric header, bytes 12-13 carry the fabric type and
    // the type word and payload prefix move 16 bytes later. Frames shorter than
    // the planted positions are simply cut off.
    task automatic send_frame(input int len, input logic fab,
                              input logic [TYPE_W-1:0] tval,
                              input logic [TYPE_W-1:0] pfx);
        int                base;
        logic [BYTE_W-1:0] b;
        base = fab ? FABRIC_SKIP : 0;
        for (int i = 0; i < len; i++) begin
            b = BYTE_W'($urandom);
            if (fab && i == SA_END)
                b = FABRIC_TYPE[15:8];
            else if (fab && i == SA_END + 1)
                b = FABRIC_TYPE[7:0];
            if (i == base + SA_END)
                b = tval[15:8];
            else if (i == base + SA_END + 1)
                b = tval[7:0];
            else if (i == base + HDR_LEN)
                b = pfx[15:8];
            else if (i == base + HDR_LEN + 1)
                b = pfx[7:0];
            send_byte(b, i == len - 1);
        end
        frames_sent++;
    endtask

    // Mostly well-formed frames of each class with random content, plus short
    // frames around both truncation limits and some unmarked noise frames.
    task automatic random_frame();
        int                kind;
        int                len;
        logic              fab;
        logic [TYPE_W-1:0] tval;
        logic [TYPE_W-1:0] pfx;
        kind = $urandom_range(99);
        fab  = ($urandom_range(3) == 0);
        len  = ($urandom_range(29) == 0) ? $urandom_range(700, 17) : $urandom_range(64, 17);
        tval = TYPE_W'($urandom);
        case ($urandom_range(3))
            0:       pfx = SNAP_PREFIX;
            1:       pfx = IPX_PREFIX;
            2:       pfx = {SNAP_PREFIX[15:8], BYTE_W'($urandom)};
            default: pfx = TYPE_W'($urandom);
        endcase
        if (kind < 40) begin
            tval = TYPE_W'($urandom_range(TYPE_ALL_ONES, ETHERTYPE_MIN));
        end else if (kind < 70) begin
            // Small length fields make the clamp to the length field common.
            tval = ($urandom_range(1) == 0) ? TYPE_W'($urandom_range(48))
                                            : TYPE_W'($urandom_range(LEN_MAX_8023));
        end else if (kind < 78) begin
            tval = TYPE_W'($urandom_range(ETHERTYPE_MIN - 1, LEN_MAX_8023 + 1));
        end else if (kind < 90) begin
            len = fab ? $urandom_range(33, 29) - FABRIC_SKIP
                      : $urandom_range(SHORT_FRAME_MAX + 1, 1);
        end else begin
            fab = 1'b0;
        end
        send_frame(len + (fab ? FABRIC_SKIP : 0), fab, tval, pfx);
    endtask

    task automatic random_phase();
        int start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < PHASE_BYTES)
            random_frame();
    endtask

    // Stop sending and wait for every expected verdict. The pending count is
    // registered in the checker, so it is read only from the next edge on.
    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_key(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Writes all three keys, then a stray write to the unused index, which must
    // leave them as they are.
    task automatic write_keys(input logic [KEY_W-1:0] k_snap, input logic [KEY_W-1:0] k_ipx,
                              input logic [KEY_W-1:0] k_llc);
        put_key(CFG_SNAP_KEY, k_snap);
        put_key(CFG_RAW_IPX_KEY, k_ipx);
        put_key(CFG_LLC_KEY, k_llc);
        put_key(CFG_BAD_INDEX, KEY_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Watchdog: a hung handshake or a lost verdict ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Watchdog expired after %0d cycles with %0d verdicts pending",
                 cycle_count, pending);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        // Every input of the block is known from time zero.
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.frame_byte = '0;
        byte_ch.last_byte  = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.reg_index   = CFG_SNAP_KEY;
        cfg_ch.wr_data     = '0;
        res_ch.ready       = 1'b0;
        src_idle_pct       = 31;
        snk_idle_pct       = 57;
        stall_token        = 0;
        bytes_sent         = 0;
        frames_sent        = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames, with the keys still at their reset value of zero.
        // A single-byte frame and a 16-byte frame are both too short.
        send_frame(1, 1'b0, ETYPE_IPV4, SNAP_PREFIX);
        send_frame(SHORT_FRAME_MAX, 1'b0, ETYPE_IPV4, SNAP_PREFIX);
        // The smallest and largest EtherTypes.
        send_frame(SHORT_FRAME_MAX + 1, 1'b0, ETHERTYPE_MIN, IPX_PREFIX);
        send_frame(40, 1'b0, TYPE_ALL_ONES, SNAP_PREFIX);
        // Both ends of the undefined gap between length and EtherType.
        send_frame(40, 1'b0, ETHERTYPE_MIN - 1, SNAP_PREFIX);
        send_frame(40, 1'b0, LEN_MAX_8023 + 1, IPX_PREFIX);
        // 802.3 at the largest length, a clamped raw IPX frame and a zero-length
        // LLC frame whose prefix only half matches SNAP.
        send_frame(40, 1'b0, LEN_MAX_8023, SNAP_PREFIX);
        send_frame(40, 1'b0, 16'd10, IPX_PREFIX);
        send_frame(40, 1'b0, 16'd0, {SNAP_PREFIX[15:8], 8'h00});
        send_frame(SHORT_FRAME_MAX + 2, 1'b0, 16'd1, IPX_PREFIX);
        // Fabric frames: header cut short, a single payload byte (too short for
        // the 802.3 prefix), the first full SNAP frame, and an inner fabric type.
        send_frame(FABRIC_SKIP + HDR_LEN, 1'b1, ETYPE_IPV4, SNAP_PREFIX);
        send_frame(FABRIC_SKIP + HDR_LEN + 1, 1'b1, 16'd20, SNAP_PREFIX);
        send_frame(FABRIC_SKIP + PFX_END, 1'b1, 16'd20, SNAP_PREFIX);
        send_frame(60, 1'b1, FABRIC_TYPE, IPX_PREFIX);
        drain();

        // First random phase: the sender idles less than the receiver.
        write_keys(KEY_ALL_ONES, '0, KEY_W'($urandom));
        random_phase();
        drain();

        // Second phase: idle rates swapped.
        src_idle_pct = 57;
        snk_idle_pct = 31;
        write_keys('0, KEY_ALL_ONES, '0);
        random_phase();
        drain();

        // Third phase: nobody idles. It opens with a long receiver hold-off while
        // the sender keeps offering short frames, so the pipeline fills and the
        // byte input stalls until the receiver lets go.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_keys(KEY_W'($urandom), KEY_W'($urandom), KEY_ALL_ONES);
        stall_token <= stall_token + 1;
        for (int i = 0; i < 12; i++)
            send_frame(SHORT_FRAME_MAX + 1, 1'b0, ETYPE_IPV4, '0);
        random_phase();
        drain();

        $display("Checked %0d verdicts from %0d frames (%0d bytes) under four key settings,",
                 checked, frames_sent, bytes_sent);
        $display("with random idling on both sides, a long receiver hold-off and full drains.");
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== ethernet_frame_header_classifier_top.f =====
hw/rtl/efhc_pkg.sv
hw/rtl/efhc_if.sv
hw/rtl/efhc_frame_parser.sv
hw/rtl/efhc_classifier.sv
hw/rtl/ethernet_frame_header_classifier_top.sv
tb/sv/efhc_verdict_checker.sv
tb/sv/tb.sv
